@@ src/tsoam_pkg.sv @@
// Shared types and constants for the transistor safe-operating-area monitor.
// Holds the word structs, configuration struct, register codes and sizing constants.
// No dependencies.
package tsoam_pkg;

  // Block constants
  localparam int MAX_WARNS         = 5;
  localparam int DEVICE_MULTIPLIER = 1;

  localparam int NUM_CHK = 6;
  localparam int CNT_W   = (MAX_WARNS > 0) ? $clog2(MAX_WARNS + 1) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WARNS);

  // Field widths
  localparam int V_W       = 16;
  localparam int I_W       = 24;
  localparam int T_W       = 14;
  localparam int VLIM_W    = 15;
  localparam int ILIM_W    = 23;
  localparam int PWR_OUT_W = 44;
  localparam int SLOPE_W   = 32;

  // Configuration port
  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 3;

  // Power datapath widths
  localparam int PROD_W = V_W + I_W;       // signed current * voltage
  localparam int MAG_W  = PROD_W - 1;      // magnitude of one product
  localparam int PSUM_W = MAG_W + 3;       // signed sum of three magnitudes and charge term
  localparam int MULT_W = $clog2(DEVICE_MULTIPLIER + 1) + 1;
  localparam int PWR_W  = PSUM_W + MULT_W;
  localparam int CMP_W  = (PWR_W > PWR_OUT_W + 2) ? PWR_W : PWR_OUT_W + 2;
  localparam int RED_W  = T_W + SLOPE_W;

  localparam logic signed [MULT_W-1:0] DEV_MULT_S = MULT_W'(DEVICE_MULTIPLIER);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_VBE_LIMIT    = 3'd0,
    REG_VBC_LIMIT    = 3'd1,
    REG_VCE_LIMIT    = 3'd2,
    REG_IC_LIMIT     = 3'd3,
    REG_IB_LIMIT     = 3'd4,
    REG_POWER_LIMIT  = 3'd5,
    REG_NOMINAL_TEMP = 3'd6,
    REG_DERATE_SLOPE = 3'd7
  } tsoam_reg_e;

  typedef struct packed {
    logic [VLIM_W-1:0]    vbe_limit;
    logic [VLIM_W-1:0]    vbc_limit;
    logic [VLIM_W-1:0]    vce_limit;
    logic [ILIM_W-1:0]    ic_limit;
    logic [ILIM_W-1:0]    ib_limit;
    logic [PWR_OUT_W-1:0] power_limit;
    logic [T_W-1:0]       nominal_temp;
    logic [SLOPE_W-1:0]   derate_slope;
  } tsoam_cfg_t;

  localparam tsoam_cfg_t CFG_RESET = '{
    vbe_limit:    '1,
    vbc_limit:    '1,
    vce_limit:    '1,
    ic_limit:     '1,
    ib_limit:     '1,
    power_limit:  '1,
    nominal_temp: T_W'(4773),
    derate_slope: '0
  };

  typedef struct packed {
    logic                  clear_counts;
    logic signed [V_W-1:0] vbe_internal;
    logic signed [V_W-1:0] vbc_internal;
    logic signed [V_W-1:0] vce_external;
    logic signed [V_W-1:0] vbe_external;
    logic signed [V_W-1:0] v_substrate;
    logic signed [I_W-1:0] collector_current;
    logic signed [I_W-1:0] base_current;
    logic signed [I_W-1:0] substrate_current;
    logic signed [I_W-1:0] substrate_charge_current;
    logic [T_W-1:0]        device_temp;
    logic                  transient_mode;
  } tsoam_in_t;

  typedef struct packed {
    logic                 warn_vbe;
    logic                 warn_vbc;
    logic                 warn_vce;
    logic                 warn_ic;
    logic                 warn_ib;
    logic                 warn_power;
    logic [PWR_OUT_W-1:0] power;
    logic [PWR_OUT_W-1:0] derated_limit;
  } tsoam_out_t;

  // One flag per check, shared by the limit checks and the warning counters
  typedef struct packed {
    logic vbe;
    logic vbc;
    logic vce;
    logic ic;
    logic ib;
    logic power;
  } tsoam_flags_t;

endpackage

@@ src/tsoam_regs.sv @@
// APB-style configuration registers of the safe-operating-area monitor.
// Depends on tsoam_pkg for the register codes and the configuration struct.
module tsoam_regs import tsoam_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output tsoam_cfg_t        cfg_o
);

  tsoam_cfg_t cfg_q;
  tsoam_reg_e reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = tsoam_reg_e'(paddr[ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_VBE_LIMIT:    cfg_q.vbe_limit    <= pwdata[VLIM_W-1:0];
        REG_VBC_LIMIT:    cfg_q.vbc_limit    <= pwdata[VLIM_W-1:0];
        REG_VCE_LIMIT:    cfg_q.vce_limit    <= pwdata[VLIM_W-1:0];
        REG_IC_LIMIT:     cfg_q.ic_limit     <= pwdata[ILIM_W-1:0];
        REG_IB_LIMIT:     cfg_q.ib_limit     <= pwdata[ILIM_W-1:0];
        REG_POWER_LIMIT:  cfg_q.power_limit  <= pwdata[PWR_OUT_W-1:0];
        REG_NOMINAL_TEMP: cfg_q.nominal_temp <= pwdata[T_W-1:0];
        REG_DERATE_SLOPE: cfg_q.derate_slope <= pwdata[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_VBE_LIMIT:    prdata = DATA_W'(cfg_q.vbe_limit);
      REG_VBC_LIMIT:    prdata = DATA_W'(cfg_q.vbc_limit);
      REG_VCE_LIMIT:    prdata = DATA_W'(cfg_q.vce_limit);
      REG_IC_LIMIT:     prdata = DATA_W'(cfg_q.ic_limit);
      REG_IB_LIMIT:     prdata = DATA_W'(cfg_q.ib_limit);
      REG_POWER_LIMIT:  prdata = DATA_W'(cfg_q.power_limit);
      REG_NOMINAL_TEMP: prdata = DATA_W'(cfg_q.nominal_temp);
      REG_DERATE_SLOPE: prdata = DATA_W'(cfg_q.derate_slope);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/tsoam_core.sv @@
// Limit checks, power sum and derated power limit for one sample word.
// Purely combinational; depends on tsoam_pkg for widths and word structs.
module tsoam_core import tsoam_pkg::*; (
  input  tsoam_in_t             item_i,
  input  tsoam_cfg_t            cfg_i,
  output tsoam_flags_t          exc_o,
  output logic [PWR_OUT_W-1:0]  power_o,
  output logic [PWR_OUT_W-1:0]  lim_o
);

  logic signed [V_W:0]     vce_int;
  logic [V_W-1:0]          vbe_mag, vbc_mag, vsub_mag;
  logic [V_W:0]            vce_mag;
  logic [I_W-1:0]          ic_mag, ib_mag;

  logic signed [PROD_W-1:0] p_ic, p_ib, p_sub;
  logic signed [PROD_W:0]   p_q;
  logic [MAG_W-1:0]         m_ic, m_ib, m_sub;
  logic signed [PSUM_W-1:0] q_term, psum;
  logic signed [PWR_W-1:0]  pwr;
  logic signed [CMP_W-1:0]  pwr_ext, lim_ext;

  logic [T_W-1:0]          dt;
  logic                    derate_on;
  logic [RED_W-1:0]        red;
  logic [RED_W:0]          diff;

  // Voltage and current magnitudes; the most negative code maps to its true magnitude
  assign vbe_mag  = item_i.vbe_internal[V_W-1] ? (~item_i.vbe_internal + 1'b1)
                                               : item_i.vbe_internal;
  assign vbc_mag  = item_i.vbc_internal[V_W-1] ? (~item_i.vbc_internal + 1'b1)
                                               : item_i.vbc_internal;
  assign vsub_mag = item_i.v_substrate[V_W-1]  ? (~item_i.v_substrate + 1'b1)
                                               : item_i.v_substrate;
  assign vce_int  = {item_i.vbe_internal[V_W-1], item_i.vbe_internal}
                  - {item_i.vbc_internal[V_W-1], item_i.vbc_internal};
  assign vce_mag  = vce_int[V_W] ? (~vce_int + 1'b1) : vce_int;
  assign ic_mag   = item_i.collector_current[I_W-1] ? (~item_i.collector_current + 1'b1)
                                                    : item_i.collector_current;
  assign ib_mag   = item_i.base_current[I_W-1] ? (~item_i.base_current + 1'b1)
                                               : item_i.base_current;

  assign exc_o.vbe = vbe_mag > {1'b0, cfg_i.vbe_limit};
  assign exc_o.vbc = vbc_mag > {1'b0, cfg_i.vbc_limit};
  assign exc_o.vce = vce_mag > {2'b00, cfg_i.vce_limit};
  assign exc_o.ic  = ic_mag  > {1'b0, cfg_i.ic_limit};
  assign exc_o.ib  = ib_mag  > {1'b0, cfg_i.ib_limit};

  // Power: three product magnitudes plus the signed charge term in transient mode
  assign p_ic  = item_i.collector_current * item_i.vce_external;
  assign p_ib  = item_i.base_current * item_i.vbe_external;
  assign p_sub = item_i.substrate_current * item_i.v_substrate;
  assign p_q   = item_i.substrate_charge_current * $signed({1'b0, vsub_mag});

  assign m_ic  = p_ic[PROD_W-1]  ? MAG_W'(-p_ic)  : MAG_W'(p_ic);
  assign m_ib  = p_ib[PROD_W-1]  ? MAG_W'(-p_ib)  : MAG_W'(p_ib);
  assign m_sub = p_sub[PROD_W-1] ? MAG_W'(-p_sub) : MAG_W'(p_sub);

  assign q_term = item_i.transient_mode
                ? {{(PSUM_W-PROD_W-1){p_q[PROD_W]}}, p_q} : '0;
  assign psum   = $signed({{(PSUM_W-MAG_W){1'b0}}, m_ic})
                + $signed({{(PSUM_W-MAG_W){1'b0}}, m_ib})
                + $signed({{(PSUM_W-MAG_W){1'b0}}, m_sub})
                + q_term;
  assign pwr     = psum * DEV_MULT_S;
  assign pwr_ext = CMP_W'(pwr);

  // Derated limit, clamped at zero
  assign dt        = item_i.device_temp - cfg_i.nominal_temp;
  assign derate_on = (cfg_i.derate_slope != '0) && (item_i.device_temp > cfg_i.nominal_temp);
  assign red       = RED_W'(dt) * RED_W'(cfg_i.derate_slope);
  assign diff      = {{(RED_W+1-PWR_OUT_W){1'b0}}, cfg_i.power_limit} - {1'b0, red};

  always_comb begin
    if (!derate_on) begin
      lim_o = cfg_i.power_limit;
    end else if (diff[RED_W]) begin
      lim_o = '0;
    end else begin
      lim_o = diff[PWR_OUT_W-1:0];
    end
  end

  assign lim_ext     = $signed({{(CMP_W-PWR_OUT_W){1'b0}}, lim_o});
  assign exc_o.power = pwr_ext > lim_ext;

  // Saturate the reported power to the output range
  always_comb begin
    if (pwr_ext[CMP_W-1]) begin
      power_o = '0;
    end else if (|pwr_ext[CMP_W-2:PWR_OUT_W]) begin
      power_o = '1;
    end else begin
      power_o = pwr_ext[PWR_OUT_W-1:0];
    end
  end

endmodule

@@ src/tsoam_warn.sv @@
// Warning counters of the safe-operating-area monitor: one saturating counter per check.
// Depends on tsoam_pkg for the flag struct and the warning budget.
module tsoam_warn import tsoam_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         upd_i,
  input  logic         clr_i,
  input  tsoam_flags_t exc_i,
  output tsoam_flags_t warn_o
);

  logic [NUM_CHK-1:0]            exc_vec, warn_vec;
  logic [NUM_CHK-1:0][CNT_W-1:0] cnt_q, cnt_d;

  assign exc_vec = exc_i;

  // Warn only while the budget lasts; the counter advances with the warning
  always_comb begin
    for (int k = 0; k < NUM_CHK; k++) begin
      warn_vec[k] = exc_vec[k] && (cnt_q[k] < MAX_CNT);
      if (clr_i) begin
        cnt_d[k] = '0;
      end else if (warn_vec[k]) begin
        cnt_d[k] = cnt_q[k] + 1'b1;
      end else begin
        cnt_d[k] = cnt_q[k];
      end
    end
  end

  assign warn_o = clr_i ? '0 : warn_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (upd_i) begin
      cnt_q <= cnt_d;
    end
  end

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && clr_i |=> cnt_q == '0)
    else $error("warning counters not zero after clear");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i |=> $stable(cnt_q))
    else $error("warning counters moved without a word");

  for (genvar k = 0; k < NUM_CHK; k++) begin : g_chk
    a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q[k] <= MAX_CNT)
      else $error("warning counter above budget");

    a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
      upd_i && !clr_i && warn_vec[k] |=> cnt_q[k] == $past(cnt_q[k]) + 1'b1)
      else $error("warning raised without counter advance");
  end

endmodule

@@ src/transistor_safe_operating_area_monitor_top.sv @@
// Top level of the transistor safe-operating-area monitor.
// Instantiates tsoam_regs, tsoam_core and tsoam_warn; depends on tsoam_pkg.
//
// Each input word is one operating-point sample; each accepted word yields exactly one result
// word through the input register, then the result register, and a new word can be taken
// every cycle unless out_ready_i stalls the output, so sustained throughput is one word per
// clock. That rate is set by the compute stage, which checks the limits, forms the power sum
// and derated limit and updates the six warning counters. A word with clear_counts set
// zeroes the counters and returns an all-zero result. Registers sit on the APB port at byte
// address 8*i with 64-bit data: vbe_limit, vbc_limit, vce_limit, ic_limit, ib_limit,
// power_limit, nominal_temp, derate_slope; write them only while no word is in flight.
module transistor_safe_operating_area_monitor_top import tsoam_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tsoam_in_t         in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tsoam_out_t        out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  tsoam_cfg_t           cfg;
  tsoam_flags_t         exc, warn;
  logic [PWR_OUT_W-1:0] power, lim;

  logic       s1_valid_q, s1_valid_d;
  tsoam_in_t  s1_data_q;
  logic       out_valid_q, out_valid_d;
  tsoam_out_t res_q, res_d;
  logic       in_fire, s1_adv;

  tsoam_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsoam_core u_core (
    .item_i  (s1_data_q),
    .cfg_i   (cfg),
    .exc_o   (exc),
    .power_o (power),
    .lim_o   (lim)
  );

  tsoam_warn u_warn (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (s1_adv),
    .clr_i  (s1_data_q.clear_counts),
    .exc_i  (exc),
    .warn_o (warn)
  );

  // Advance the input stage whenever the result register is free or being drained
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_fire     = in_valid_i && in_ready_o;
  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_ready_i);

  always_comb begin
    if (s1_data_q.clear_counts) begin
      res_d = '0;
    end else begin
      res_d.warn_vbe      = warn.vbe;
      res_d.warn_vbc      = warn.vbc;
      res_d.warn_vce      = warn.vce;
      res_d.warn_ic       = warn.ic;
      res_d.warn_ib       = warn.ib;
      res_d.warn_power    = warn.power;
      res_d.power         = power;
      res_d.derated_limit = lim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule
